@@ rtl/core/clpc_pkg.sv @@
`default_nettype none
package clpc_pkg;

  localparam int TAB_BITS   = 15;
  localparam int TAB_DEPTH  = 1 << TAB_BITS;
  localparam int CHAN_BITS  = 8;
  localparam int ADDR_SPAN  = 3 * CHAN_BITS;
  localparam int SHIFT_BITS = 4;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CHAN_BITS-1:0]  CHAN_MAX  = 8'hFF;
  localparam logic [SHIFT_BITS-1:0] SHIFT_MAX = 4'd8;
  localparam logic [SHIFT_BITS-1:0] SHIFT_RST = 4'd3;

  // command codes
  localparam logic [1:0] CMD_CLASSIFY = 2'd0;
  localparam logic [1:0] CMD_PAINT    = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_CH0 = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_CH1 = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_CH2 = 2'd2;

  typedef struct packed {
    logic any;
    logic [CHAN_BITS-1:0] lo;
    logic [CHAN_BITS-1:0] hi;
  } range_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;    // capture the accepted item
    logic decode;      // set up result, walk bounds and read address
    logic read_take;   // capture table read data
    logic walk_step;   // paint one cell and advance
    logic wipe_init;   // start a fill pass with zero
    logic fill_init;   // start a fill pass with the item's class value
    logic fill_step;   // write one entry of the fill pass
    logic out_load;    // move the result into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic overflow;
    logic walk_any;
    logic walk_last;
    logic fill_last;
    logic cfg_hit;
  } dp_stat_t;

  function automatic logic [SHIFT_BITS-1:0] eff_shift(input logic [SHIFT_BITS-1:0] s);
    return (s > SHIFT_MAX) ? SHIFT_MAX : s;
  endfunction

  // cells touched along one channel by the stepped paint walk
  function automatic range_t chan_range(input logic [CHAN_BITS-1:0] c,
                                        input logic [CHAN_BITS-1:0] r,
                                        input logic [SHIFT_BITS-1:0] sh);
    logic signed [CHAN_BITS+1:0] start;
    logic [CHAN_BITS:0]   sum;
    logic [CHAN_BITS:0]   mask_w;
    logic [CHAN_BITS-1:0] stop;
    logic [CHAN_BITS-1:0] mask;
    logic [CHAN_BITS-1:0] first;
    logic [CHAN_BITS-1:0] span;
    range_t rg;
    start  = signed'({2'b00, c}) - signed'({2'b00, r});
    sum    = {1'b0, c} + {1'b0, r};
    stop   = sum[CHAN_BITS] ? CHAN_MAX : sum[CHAN_BITS-1:0];
    mask_w = (9'd1 << sh) - 9'd1;
    mask   = mask_w[CHAN_BITS-1:0];
    // negative start: first point at or above zero is the residue mod the step
    first  = start[CHAN_BITS+1] ? (start[CHAN_BITS-1:0] & mask) : start[CHAN_BITS-1:0];
    span   = (stop - first) >> sh;
    rg.any = (first <= stop);
    rg.lo  = first >> sh;
    rg.hi  = rg.lo + span;
    return rg;
  endfunction

  function automatic logic [TAB_BITS-1:0] table_addr(input logic [CHAN_BITS-1:0] p0,
                                                     input logic [CHAN_BITS-1:0] p1,
                                                     input logic [CHAN_BITS-1:0] p2,
                                                     input logic [SHIFT_BITS-1:0] w0,
                                                     input logic [SHIFT_BITS-1:0] w1);
    logic [SHIFT_BITS:0] w01;
    logic [ADDR_SPAN-1:0] a;
    w01 = {1'b0, w0} + {1'b0, w1};
    a = ADDR_SPAN'(p0) | (ADDR_SPAN'(p1) << w0) | (ADDR_SPAN'(p2) << w01);
    return a[TAB_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/clpc_if.sv @@
`default_nettype none
interface clpc_pix_if;
  import clpc_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic [CHAN_BITS-1:0] chan0;
  logic [CHAN_BITS-1:0] chan1;
  logic [CHAN_BITS-1:0] chan2;
  logic [CHAN_BITS-1:0] radius0;
  logic [CHAN_BITS-1:0] radius1;
  logic [CHAN_BITS-1:0] radius2;
  logic [CHAN_BITS-1:0] class_value;

  modport source (output valid, cmd, chan0, chan1, chan2, radius0, radius1, radius2,
                  class_value, input ready);
  modport sink (input valid, cmd, chan0, chan1, chan2, radius0, radius1, radius2,
                class_value, output ready);
endinterface

interface clpc_res_if;
  import clpc_pkg::*;
  logic valid;
  logic ready;
  logic [CHAN_BITS-1:0] class_id;
  logic status;

  modport source (output valid, class_id, status, input ready);
  modport sink (input valid, class_id, status, output ready);
endinterface
`default_nettype wire

@@ rtl/core/color_lut_pixel_classifier.sv @@
`default_nettype none
// Colour lookup-table classifier. Each channel is shifted right by its shift
// register (values above 8 act as 8) and the three cell indexes are packed,
// channel 0 lowest, into an address of a 32768-byte class table held in one
// single-port-write RAM. One item is worked at a time: classify goes through
// decode, table read and finish; paint box writes each painted cell in turn
// and clear writes every table entry in turn, through the one write port.
// After reset, and after a write to a shift register that arrives while idle,
// the table is zeroed in a pass over every entry, during which no item is
// accepted. If the shifts need more than 15 address bits, every command answers
// class 0 with status 1 and leaves the table alone. A finished result waits in
// an output register, so the next item can be taken before it is collected.
module color_lut_pixel_classifier
  import clpc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  clpc_pix_if.sink                     pix,
  clpc_res_if.source                   res,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [SHIFT_BITS-1:0]   cfg_data
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  clpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .ctl       (ctl)
  );

  clpc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctl        (ctl),
    .stat       (stat),
    .pix        (pix),
    .out_class  (res.class_id),
    .out_status (res.status)
  );

endmodule
`default_nettype wire

@@ rtl/core/clpc_ram.sv @@
`default_nettype none
module clpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/clpc_dp.sv @@
`default_nettype none
module clpc_dp
  import clpc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [SHIFT_BITS-1:0]   cfg_data,
  input  wire ctrl_cmd_t               ctl,
  output dp_stat_t                     stat,
  clpc_pix_if.sink                     pix,
  output logic [CHAN_BITS-1:0]         out_class,
  output logic                         out_status
);

  logic [SHIFT_BITS-1:0] shift0, shift1, shift2;
  logic [SHIFT_BITS-1:0] sh0, sh1, sh2, w0, w1, w2;
  logic [SHIFT_BITS:0]   wsum;
  logic overflow;

  logic [1:0]           cmd_q;
  logic [CHAN_BITS-1:0] ch0, ch1, ch2, rad0, rad1, rad2, val_q;

  range_t rg0, rg1, rg2;
  logic [CHAN_BITS-1:0] lo0, lo1, hi0, hi1, hi2;
  logic [CHAN_BITS-1:0] pos0, pos1, pos2;
  logic [CHAN_BITS-1:0] pos0_next, pos1_next, pos2_next;

  logic [TAB_BITS-1:0]  clear_index;
  logic [CHAN_BITS-1:0] fill_val;

  logic [CHAN_BITS-1:0] res_class;
  logic                 res_status;

  logic                 ram_we;
  logic [TAB_BITS-1:0]  ram_waddr, ram_raddr;
  logic [CHAN_BITS-1:0] ram_wdata, ram_rdata;

  // shift registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shift0 <= SHIFT_RST;
      shift1 <= SHIFT_RST;
      shift2 <= SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHIFT_CH0: shift0 <= cfg_data;
        REG_SHIFT_CH1: shift1 <= cfg_data;
        REG_SHIFT_CH2: shift2 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sh0 = eff_shift(shift0);
  assign sh1 = eff_shift(shift1);
  assign sh2 = eff_shift(shift2);
  assign w0  = SHIFT_MAX - sh0;
  assign w1  = SHIFT_MAX - sh1;
  assign w2  = SHIFT_MAX - sh2;
  assign wsum = {1'b0, w0} + {1'b0, w1} + {1'b0, w2};
  assign overflow = (wsum > (SHIFT_BITS+1)'(TAB_BITS));

  // input item capture
  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd_q <= pix.cmd;
      ch0   <= pix.chan0;
      ch1   <= pix.chan1;
      ch2   <= pix.chan2;
      rad0  <= pix.radius0;
      rad1  <= pix.radius1;
      rad2  <= pix.radius2;
      val_q <= pix.class_value;
    end
  end

  assign rg0 = chan_range(ch0, rad0, sh0);
  assign rg1 = chan_range(ch1, rad1, sh1);
  assign rg2 = chan_range(ch2, rad2, sh2);

  // paint walk: channel 0 fastest
  always_comb begin
    pos0_next = pos0 + 8'd1;
    pos1_next = pos1;
    pos2_next = pos2;
    if (pos0 == hi0) begin
      pos0_next = lo0;
      pos1_next = pos1 + 8'd1;
      if (pos1 == hi1) begin
        pos1_next = lo1;
        pos2_next = pos2 + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos0 <= '0;
      pos1 <= '0;
      pos2 <= '0;
    end else if (ctl.decode) begin
      lo0  <= rg0.lo;
      lo1  <= rg1.lo;
      hi0  <= rg0.hi;
      hi1  <= rg1.hi;
      hi2  <= rg2.hi;
      pos0 <= rg0.lo;
      pos1 <= rg1.lo;
      pos2 <= rg2.lo;
    end else if (ctl.walk_step) begin
      pos0 <= pos0_next;
      pos1 <= pos1_next;
      pos2 <= pos2_next;
    end
  end

  // fill pass, used at reset, after a shift write and by the clear command
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_index <= '0;
      fill_val    <= '0;
    end else if (ctl.wipe_init) begin
      clear_index <= '0;
      fill_val    <= '0;
    end else if (ctl.fill_init) begin
      clear_index <= '0;
      fill_val    <= val_q;
    end else if (ctl.fill_step) begin
      clear_index <= clear_index + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.decode) begin
      res_class  <= '0;
      res_status <= overflow;
    end else if (ctl.read_take) begin
      res_class  <= ram_rdata;
    end
    if (ctl.out_load) begin
      out_class  <= res_class;
      out_status <= res_status;
    end
  end

  assign ram_we    = ctl.fill_step || ctl.walk_step;
  assign ram_waddr = ctl.fill_step ? clear_index : table_addr(pos0, pos1, pos2, w0, w1);
  assign ram_wdata = ctl.fill_step ? fill_val : val_q;
  assign ram_raddr = table_addr(ch0 >> sh0, ch1 >> sh1, ch2 >> sh2, w0, w1);

  clpc_ram #(
    .WIDTH (CHAN_BITS),
    .DEPTH (TAB_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign stat.cmd       = cmd_q;
  assign stat.overflow  = overflow;
  assign stat.walk_any  = rg0.any && rg1.any && rg2.any;
  assign stat.walk_last = (pos0 == hi0) && (pos1 == hi1) && (pos2 == hi2);
  assign stat.fill_last = &clear_index;
  assign stat.cfg_hit   = cfg_we && (cfg_index == REG_SHIFT_CH0 ||
                                     cfg_index == REG_SHIFT_CH1 ||
                                     cfg_index == REG_SHIFT_CH2);

endmodule
`default_nettype wire

@@ rtl/core/clpc_ctrl.sv @@
`default_nettype none
module clpc_ctrl
  import clpc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire dp_stat_t stat,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output ctrl_cmd_t     ctl
);

  typedef enum logic [2:0] {
    S_WIPE,    // zero the table (reset, shift write)
    S_IDLE,
    S_DECODE,
    S_READ,
    S_PAINT,
    S_FILL,    // clear command
    S_FIN
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE) && !stat.cfg_hit;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    ctl = '0;
    case (state)
      S_WIPE:   ctl.fill_step = 1'b1;
      S_IDLE: begin
        ctl.latch_in  = in_valid && in_ready;
        ctl.wipe_init = stat.cfg_hit;
      end
      S_DECODE: begin
        ctl.decode    = 1'b1;
        ctl.fill_init = !stat.overflow && stat.cmd == CMD_CLEAR;
      end
      S_READ:   ctl.read_take = 1'b1;
      S_PAINT:  ctl.walk_step = 1'b1;
      S_FILL:   ctl.fill_step = 1'b1;
      S_FIN:    ctl.out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WIPE;
      out_valid <= 1'b0;
    end else begin
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_WIPE: begin
          if (stat.fill_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (stat.cfg_hit) begin
            state <= S_WIPE;
          end else if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (stat.overflow) begin
            state <= S_FIN;
          end else begin
            case (stat.cmd)
              CMD_CLASSIFY: state <= S_READ;
              CMD_PAINT:    state <= stat.walk_any ? S_PAINT : S_FIN;
              CMD_CLEAR:    state <= S_FILL;
              default:      state <= S_FIN;
            endcase
          end
        end
        S_READ:   state <= S_FIN;
        S_PAINT: begin
          if (stat.walk_last) state <= S_FIN;
        end
        S_FILL: begin
          if (stat.fill_last) state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sim/color_lut_pixel_classifier_tb.sv @@
module color_lut_pixel_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clpc_pkg::*;

  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int CALM_TAIL   = 200;
  localparam int SETTLE      = 16;
  localparam int MAX_CELLS   = 256;
  localparam int PHASES      = 5;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0][CHAN_BITS-1:0] chan;
    logic [2:0][CHAN_BITS-1:0] radius;
    logic [CHAN_BITS-1:0] class_value;
  } pix_item_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] class_id;
    logic status;
  } lut_res_t;

  typedef enum logic {ROW_ITEM, ROW_SHIFTS} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    pix_item_t item;
    logic typed;
    lut_res_t want;
    logic [2:0][SHIFT_BITS-1:0] shifts;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [SHIFT_BITS-1:0] cfg_data;

  clpc_pix_if pix_ch();
  clpc_res_if res_ch();

  color_lut_pixel_classifier uut (
    .clk(clk),
    .rst(rst),
    .pix(pix_ch),
    .res(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the class table and shift registers
  logic [CHAN_BITS-1:0] lut_cells [TAB_DEPTH];
  logic [SHIFT_BITS-1:0] lut_shift [3];
  lut_res_t lut_answers [$];

  dir_row_t dir_rows [$];
  pix_item_t last_paint;
  bit have_paint = 1'b0;
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  int fails = 0;
  int cycle_count = 0;

  int phase_items [PHASES] = '{350, 350, 80, 350, 800};
  int phase_sh [PHASES][3] = '{'{3, 3, 3}, '{8, 0, 12}, '{0, 0, 0}, '{5, 2, 6},
                               '{0, 0, 0}};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void fill_cells(input logic [CHAN_BITS-1:0] v);
    foreach (lut_cells[k]) lut_cells[k] = v;
  endfunction

  function automatic int cell_shift(input int i);
    return (lut_shift[i] > SHIFT_MAX) ? int'(SHIFT_MAX) : int'(lut_shift[i]);
  endfunction

  // cell index range that the stepped walk covers along one channel
  function automatic bit paint_span(input int c, input int r, input int sh,
                                    output int lo, output int hi);
    int start, stop, first, k;
    start = c - r;
    stop = c + r;
    if (stop > int'(CHAN_MAX)) stop = int'(CHAN_MAX);
    if (start < 0) begin
      k = (-start + (1 << sh) - 1) >> sh;
      first = start + (k << sh);
    end else begin
      first = start;
    end
    lo = 0;
    hi = 0;
    if (first > stop) return 1'b0;
    lo = first >> sh;
    hi = lo + ((stop - first) >> sh);
    return 1'b1;
  endfunction

  function automatic int paint_cells(input pix_item_t it);
    int lo, hi, n, i;
    n = 1;
    for (i = 0; i < 3; i++) begin
      if (!paint_span(int'(it.chan[i]), int'(it.radius[i]), cell_shift(i), lo, hi)) return 0;
      n = n * (hi - lo + 1);
    end
    return n;
  endfunction

  function automatic lut_res_t lut_answer(input pix_item_t it);
    int sh [3];
    int wd [3];
    int lo [3];
    int hi [3];
    int a, i, p0, p1, p2;
    bit hit;
    lut_res_t r;
    r = '0;
    for (i = 0; i < 3; i++) begin
      sh[i] = cell_shift(i);
      wd[i] = CHAN_BITS - sh[i];
    end
    if (wd[0] + wd[1] + wd[2] > TAB_BITS) begin
      r.status = 1'b1;
    end else begin
      case (it.cmd)
        CMD_CLASSIFY: begin
          a = (int'(it.chan[0]) >> sh[0])
            | ((int'(it.chan[1]) >> sh[1]) << wd[0])
            | ((int'(it.chan[2]) >> sh[2]) << (wd[0] + wd[1]));
          r.class_id = lut_cells[a & (TAB_DEPTH - 1)];
        end
        CMD_PAINT: begin
          hit = 1'b1;
          for (i = 0; i < 3; i++)
            if (!paint_span(int'(it.chan[i]), int'(it.radius[i]), sh[i], lo[i], hi[i]))
              hit = 1'b0;
          if (hit) begin
            for (p2 = lo[2]; p2 <= hi[2]; p2++)
              for (p1 = lo[1]; p1 <= hi[1]; p1++)
                for (p0 = lo[0]; p0 <= hi[0]; p0++) begin
                  a = p0 | (p1 << wd[0]) | (p2 << (wd[0] + wd[1]));
                  lut_cells[a & (TAB_DEPTH - 1)] = it.class_value;
                end
          end
        end
        CMD_CLEAR: fill_cells(it.class_value);
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic dir_row_t item_row(input logic [1:0] cmd, input int c0, input int c1,
                                        input int c2, input int r0, input int r1,
                                        input int r2, input int v, input bit typed = 1'b0,
                                        input int cls = 0, input bit st = 1'b0);
    dir_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item.cmd = cmd;
    row.item.chan[0] = 8'(c0);
    row.item.chan[1] = 8'(c1);
    row.item.chan[2] = 8'(c2);
    row.item.radius[0] = 8'(r0);
    row.item.radius[1] = 8'(r1);
    row.item.radius[2] = 8'(r2);
    row.item.class_value = 8'(v);
    row.typed = typed;
    row.want.class_id = 8'(cls);
    row.want.status = st;
    return row;
  endfunction

  function automatic dir_row_t shift_row(input int s0, input int s1, input int s2);
    dir_row_t row;
    row = '0;
    row.kind = ROW_SHIFTS;
    row.shifts[0] = 4'(s0);
    row.shifts[1] = 4'(s1);
    row.shifts[2] = 4'(s2);
    return row;
  endfunction

  function automatic pix_item_t rand_item();
    pix_item_t it;
    int pick, i, tries, v, r;
    for (i = 0; i < 3; i++) begin
      it.chan[i] = 8'($urandom_range(0, 255));
      it.radius[i] = 8'($urandom_range(0, 255));
    end
    it.class_value = 8'($urandom_range(0, 255));
    pick = int'($urandom_range(0, 999));
    if (pick < 3) begin
      it.cmd = CMD_CLEAR;
    end else if (pick < 53) begin
      it.cmd = CMD_UNUSED;
    end else if (pick < 273) begin
      it.cmd = CMD_PAINT;
      // keep most boxes small so the walk stays short
      for (tries = 0; tries < 8; tries++) begin
        for (i = 0; i < 3; i++) begin
          case ($urandom_range(0, 3))
            0: it.radius[i] = '0;
            3: it.radius[i] = 8'($urandom_range(0, 255));
            default: it.radius[i] = 8'($urandom_range(0,
                         (cell_shift(i) >= 7) ? 255 : (2 << cell_shift(i))));
          endcase
        end
        if (paint_cells(it) <= MAX_CELLS) break;
      end
      if (tries == 8) it.radius = '0;
      last_paint = it;
      have_paint = 1'b1;
    end else begin
      it.cmd = CMD_CLASSIFY;
      if (have_paint && $urandom_range(0, 1) == 0) begin
        for (i = 0; i < 3; i++) begin
          r = int'(last_paint.radius[i]);
          v = int'(last_paint.chan[i]) + int'($urandom_range(0, 2 * r)) - r;
          if (v < 0) v = 0;
          if (v > int'(CHAN_MAX)) v = int'(CHAN_MAX);
          it.chan[i] = 8'(v);
        end
      end
    end
    return it;
  endfunction

  task automatic drain();
    pix_ch.valid <= 1'b0;
    while (lut_answers.size() != 0) @(negedge clk);
  endtask

  // each shift write rebuilds the table layout, so the shadow is zeroed too
  task automatic write_shifts(input int s0, input int s1, input int s2);
    logic [CFG_IDX_BITS-1:0] idx [3];
    int sh [3];
    int i;
    idx = '{REG_SHIFT_CH0, REG_SHIFT_CH1, REG_SHIFT_CH2};
    sh = '{s0, s1, s2};
    drain();
    for (i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= 4'(sh[i]);
      lut_shift[i] = 4'(sh[i]);
      fill_cells('0);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input pix_item_t it, input logic typed, input lut_res_t typed_res);
    lut_res_t got;
    if (src_idle && $urandom_range(0, 3) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.cmd <= it.cmd;
    pix_ch.chan0 <= it.chan[0];
    pix_ch.chan1 <= it.chan[1];
    pix_ch.chan2 <= it.chan[2];
    pix_ch.radius0 <= it.radius[0];
    pix_ch.radius1 <= it.radius[1];
    pix_ch.radius2 <= it.radius[2];
    pix_ch.class_value <= it.class_value;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    got = lut_answer(it);
    lut_answers.push_back(typed ? typed_res : got);
    @(negedge clk);
  endtask

  // result side: ready drops in bursts while idling is on
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_idle && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lut_res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (lut_answers.size() == 0) begin
        $error("result with no item pending: class_id %0d status %0d",
               res_ch.class_id, res_ch.status);
        fails++;
      end else begin
        want = lut_answers.pop_front();
        if (res_ch.class_id !== want.class_id) begin
          $error("class_id: expected %0d, got %0d", want.class_id, res_ch.class_id);
          fails++;
        end
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("color_lut_pixel_classifier_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int p, n, i, w, left;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.cmd = CMD_CLASSIFY;
    pix_ch.chan0 = '0;
    pix_ch.chan1 = '0;
    pix_ch.chan2 = '0;
    pix_ch.radius0 = '0;
    pix_ch.radius1 = '0;
    pix_ch.radius2 = '0;
    pix_ch.class_value = '0;
    fill_cells('0);
    for (i = 0; i < 3; i++) lut_shift[i] = SHIFT_RST;

    dir_rows = '{
      item_row(CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0),
      item_row(CMD_CLASSIFY, 255, 255, 255, 255, 255, 255, 255, 1'b1, 0, 1'b0),
      item_row(CMD_PAINT, 255, 255, 255, 0, 0, 0, 'hAB, 1'b1, 0, 1'b0),
      item_row(CMD_CLASSIFY, 255, 255, 255, 0, 0, 0, 0),
      item_row(CMD_CLASSIFY, 248, 249, 255, 0, 0, 0, 0),
      item_row(CMD_PAINT, 10, 250, 128, 12, 12, 12, 'hFF),
      item_row(CMD_CLASSIFY, 0, 255, 128, 0, 0, 0, 0),
      // walk starts below zero and its first step lands past the box
      item_row(CMD_PAINT, 0, 0, 0, 3, 3, 3, 'h77),
      item_row(CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0),
      item_row(CMD_UNUSED, 255, 255, 255, 255, 255, 255, 255, 1'b1, 0, 1'b0),
      item_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 'h5A, 1'b1, 0, 1'b0),
      item_row(CMD_CLASSIFY, 128, 64, 32, 0, 0, 0, 0, 1'b1, 'h5A, 1'b0),
      item_row(CMD_PAINT, 128, 128, 128, 255, 255, 255, 0),
      item_row(CMD_CLASSIFY, 201, 7, 99, 0, 0, 0, 0),
      // 24 address bits: everything answers with the overflow status
      shift_row(0, 0, 0),
      item_row(CMD_CLASSIFY, 255, 255, 255, 0, 0, 0, 0, 1'b1, 0, 1'b1),
      item_row(CMD_PAINT, 1, 2, 3, 255, 255, 255, 'hFF, 1'b1, 0, 1'b1),
      item_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 'hFF, 1'b1, 0, 1'b1),
      item_row(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b1),
      // shifts above eight saturate: the table is one cell
      shift_row(15, 9, 8),
      item_row(CMD_PAINT, 200, 17, 90, 0, 0, 0, 'hC3),
      item_row(CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0),
      item_row(CMD_CLASSIFY, 255, 255, 255, 0, 0, 0, 0),
      shift_row(0, 1, 8),
      item_row(CMD_PAINT, 255, 0, 128, 255, 1, 0, 'h81),
      item_row(CMD_CLASSIFY, 17, 0, 0, 0, 0, 0, 0),
      item_row(CMD_CLASSIFY, 17, 2, 0, 0, 0, 0, 0)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_SHIFTS)
        write_shifts(int'(dir_rows[r].shifts[0]), int'(dir_rows[r].shifts[1]),
                     int'(dir_rows[r].shifts[2]));
      else
        send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
    end

    left = 0;
    foreach (phase_items[k]) left += phase_items[k];

    for (p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        do begin
          w = 0;
          for (i = 0; i < 3; i++) begin
            phase_sh[p][i] = int'($urandom_range(0, 15));
            w += CHAN_BITS - ((phase_sh[p][i] > int'(SHIFT_MAX)) ? int'(SHIFT_MAX)
                                                                   : phase_sh[p][i]);
          end
        end while (w > TAB_BITS);
      end
      write_shifts(phase_sh[p][0], phase_sh[p][1], phase_sh[p][2]);
      for (n = 0; n < phase_items[p]; n++) begin
        if (left <= CALM_TAIL) begin
          src_idle = 1'b0;
          sink_idle = 1'b0;
        end else if ($urandom_range(0, 79) == 0) begin
          src_idle = 1'($urandom_range(0, 1));
          sink_idle = 1'($urandom_range(0, 1));
        end
        if (p == 0 && n == phase_items[0] / 2) begin
          // hold off until the table is quiet, then poke the unused index:
          // it must leave the painted table intact
          drain();
          cfg_we <= 1'b1;
          cfg_index <= REG_SPARE;
          cfg_data <= 4'($urandom_range(0, 15));
          @(negedge clk);
          cfg_we <= 1'b0;
        end
        send_item(rand_item(), 1'b0, '0);
        left--;
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk);
    if (fails == 0)
      $display("color_lut_pixel_classifier_tb: PASS");
    else
      $display("color_lut_pixel_classifier_tb: FAIL");
    $finish;
  end

endmodule
